// ===== rtl/rcpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpc_pkg: shared definitions of the ray clip block
// Field widths, register indexes, product codes, controller states and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rcpc_pkg;

   localparam int FIELD_W        = 32;
   localparam int T_W            = 31;
   localparam int CSR_IDX_W      = 3;
   localparam int DEF_FRAC_BITS  = 16;
   localparam int DEF_DATA_WIDTH = 32;
   localparam int MAC_TERMS      = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE    = 3'd6;

   // Product codes: three terms of the denominator, then four of the distance.
   localparam logic [2:0] TERM_NX_DX = 3'd0;
   localparam logic [2:0] TERM_NY_DY = 3'd1;
   localparam logic [2:0] TERM_NZ_DZ = 3'd2;
   localparam logic [2:0] TERM_NX_OX = 3'd3;
   localparam logic [2:0] TERM_NY_OY = 3'd4;
   localparam logic [2:0] TERM_NZ_OZ = 3'd5;
   localparam logic [2:0] TERM_PD_SR = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_SAT,
      ST_DECIDE,
      ST_DIV,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [2:0] mul_sel;
      logic       acc_en;
      logic [2:0] acc_sel;
      logic       sat;
      logic       parallel;
      logic       div_init;
      logic       div_step;
      logic       update;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic missed;
      logic last;
      logic denom_zero;
      logic rsp_busy;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/rcpc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpc_req_if: plane input channel
// One beat carries one bounding plane and the last-plane mark.
// ----------------------------------------------------------------------------
interface rcpc_req_if
   import rcpc_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] plane_nx;
   logic signed [FIELD_W-1:0] plane_ny;
   logic signed [FIELD_W-1:0] plane_nz;
   logic signed [FIELD_W-1:0] plane_dist;
   logic                      last_plane;

   modport source (output valid, plane_nx, plane_ny, plane_nz, plane_dist, last_plane,
                   input ready);
   modport sink   (input valid, plane_nx, plane_ny, plane_nz, plane_dist, last_plane,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/rcpc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpc_rsp_if: result channel
// One beat carries the hit flag and the entry parameter of one solid.
// ----------------------------------------------------------------------------
interface rcpc_rsp_if
   import rcpc_pkg::*;
   ;
   logic           valid;
   logic           ready;
   logic           hit;
   logic [T_W-1:0] t_entry;

   modport source (output valid, hit, t_entry, input ready);
   modport sink   (input valid, hit, t_entry, output ready);
endinterface
`default_nettype wire

// ===== rtl/rcpc_csr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpc_csr_if: configuration write channel
// One beat writes one register by index.
// ----------------------------------------------------------------------------
interface rcpc_csr_if
   import rcpc_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [FIELD_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rcpc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpc_ctrl: sequencer of the ray clip block
// Steps one plane through the products, saturation, division and update.
// ----------------------------------------------------------------------------
module rcpc_ctrl
   import rcpc_pkg::*;
#(
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);
   localparam int DIV_STEPS = DATA_WIDTH + FRAC_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] cnt_prev;

   assign cnt_prev = cnt_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               state_in = status.missed ? ST_FINISH : ST_MAC;
            end
         end
         ST_MAC: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MAC_TERMS)) begin
               state_in = ST_SAT;
               cnt_in   = '0;
            end
         end
         ST_SAT: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = status.denom_zero ? ST_FINISH : ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.last || !status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MAC: begin
            cmd.mul_en  = (cnt_ff < CNT_W'(MAC_TERMS));
            cmd.mul_sel = cnt_ff[2:0];
            cmd.acc_en  = (cnt_ff != '0);
            cmd.acc_sel = cnt_prev[2:0];
         end
         ST_SAT: begin
            cmd.sat = 1'b1;
         end
         ST_DECIDE: begin
            cmd.parallel = status.denom_zero;
            cmd.div_init = !status.denom_zero;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_FINISH: begin
            cmd.emit = status.last && !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/rcpc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpc_datapath: arithmetic and state of the ray clip block
// Registers, shared multiplier with accumulators, restoring divider,
// entry and exit tracking and the result register.
// ----------------------------------------------------------------------------
module rcpc_datapath
   import rcpc_pkg::*;
#(
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   rcpc_req_if.sink     req_if,
   rcpc_rsp_if.source   rsp_if,
   rcpc_csr_if.sink     csr_if,
   input  wire cmd_type cmd,
   output status_type   status
);
   localparam int DW    = DATA_WIDTH;
   localparam int ACC_W = 2 * FIELD_W - FRAC_BITS + 3;
   localparam int NUM_W = DW + FRAC_BITS;

   localparam logic signed [DW-1:0]    DMAX   = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] DMAX_A = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] DMIN_A = ~DMAX_A;
   localparam logic signed [63:0]      OUT_MAX = 64'sh7FFF_FFFF;

   // Configuration registers.
   logic signed [FIELD_W-1:0] ox_ff, oy_ff, oz_ff, dx_ff, dy_ff, dz_ff;
   logic [T_W-1:0]            sr_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff <= '0;
         oy_ff <= '0;
         oz_ff <= '0;
         dx_ff <= '0;
         dy_ff <= '0;
         dz_ff <= FIELD_W'(65536);
         sr_ff <= T_W'(65536);
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_ORIGIN_X: ox_ff <= csr_if.data;
            CSR_ORIGIN_Y: oy_ff <= csr_if.data;
            CSR_ORIGIN_Z: oz_ff <= csr_if.data;
            CSR_DIR_X:    dx_ff <= csr_if.data;
            CSR_DIR_Y:    dy_ff <= csr_if.data;
            CSR_DIR_Z:    dz_ff <= csr_if.data;
            CSR_SCALE:    sr_ff <= csr_if.data[T_W-1:0];
            default:      ;
         endcase
      end
   end

   // Plane latched on the accepted beat.
   logic signed [FIELD_W-1:0] nx_ff, ny_ff, nz_ff, pd_ff;
   logic                      last_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         nx_ff   <= req_if.plane_nx;
         ny_ff   <= req_if.plane_ny;
         nz_ff   <= req_if.plane_nz;
         pd_ff   <= req_if.plane_dist;
         last_ff <= req_if.last_plane;
      end
   end

   // Shared multiplier: one product per cycle, registered.
   logic signed [FIELD_W-1:0]   mul_a, mul_b;
   logic signed [2*FIELD_W-1:0] prod_in, prod_ff;
   logic signed [ACC_W-1:0]     term;
   logic signed [ACC_W-1:0]     den_acc_ff, dist_acc_ff;

   always_comb begin
      mul_a = nx_ff;
      mul_b = dx_ff;
      unique case (cmd.mul_sel)
         TERM_NX_DX: begin mul_a = nx_ff; mul_b = dx_ff; end
         TERM_NY_DY: begin mul_a = ny_ff; mul_b = dy_ff; end
         TERM_NZ_DZ: begin mul_a = nz_ff; mul_b = dz_ff; end
         TERM_NX_OX: begin mul_a = nx_ff; mul_b = ox_ff; end
         TERM_NY_OY: begin mul_a = ny_ff; mul_b = oy_ff; end
         TERM_NZ_OZ: begin mul_a = nz_ff; mul_b = oz_ff; end
         TERM_PD_SR: begin mul_a = pd_ff; mul_b = $signed({1'b0, sr_ff}); end
         default:    begin mul_a = nx_ff; mul_b = dx_ff; end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   // An arithmetic shift rounds toward minus infinity.
   assign term    = ACC_W'(prod_ff >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         den_acc_ff  <= '0;
         dist_acc_ff <= '0;
      end else if (cmd.acc_en) begin
         unique case (cmd.acc_sel) inside
            TERM_NX_DX, TERM_NY_DY, TERM_NZ_DZ: den_acc_ff  <= den_acc_ff + term;
            TERM_NX_OX, TERM_NY_OY, TERM_NZ_OZ: dist_acc_ff <= dist_acc_ff + term;
            TERM_PD_SR:                         dist_acc_ff <= dist_acc_ff - term;
            default:                            ;
         endcase
      end
   end

   // Saturation to the working width.
   logic signed [DW-1:0] denom_ff, dist_ff;

   function automatic logic signed [DW-1:0] sat_dw(input logic signed [ACC_W-1:0] v);
      logic signed [DW-1:0] r;
      if (v > DMAX_A) begin
         r = DMAX;
      end else if (v < DMIN_A) begin
         r = ~DMAX;
      end else begin
         r = DW'(v);
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.sat) begin
         denom_ff <= sat_dw(den_acc_ff);
         dist_ff  <= sat_dw(dist_acc_ff);
      end
   end

   // Restoring divider, one quotient bit per cycle.
   logic [DW-1:0]    n_mag, d_mag;
   logic [NUM_W-1:0] num_ff;
   logic [DW-1:0]    rem_ff;
   logic [DW-1:0]    quo_ff;
   logic             ovf_ff;
   logic [DW:0]      rem_shift, rem_sub;
   logic             q_bit;

   assign n_mag     = dist_ff[DW-1]  ? (~dist_ff + DW'(1))  : dist_ff;
   assign d_mag     = denom_ff[DW-1] ? (~denom_ff + DW'(1)) : denom_ff;
   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign rem_sub   = rem_shift - {1'b0, d_mag};
   assign q_bit     = (rem_shift >= {1'b0, d_mag});

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         num_ff <= {n_mag, {FRAC_BITS{1'b0}}};
         rem_ff <= '0;
         quo_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         rem_ff <= q_bit ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
         quo_ff <= {quo_ff[DW-2:0], q_bit};
         ovf_ff <= ovf_ff | quo_ff[DW-1];
      end
   end

   // Entry and exit tracking.
   logic signed [DW-1:0] entry_ff, exit_ff, entry_in, exit_in;
   logic signed [DW-1:0] q_sat, t_val;
   logic                 missed_ff;
   logic                 t_neg;

   assign q_sat = (ovf_ff || quo_ff[DW-1]) ? DMAX : $signed(quo_ff);
   assign t_neg = (dist_ff[DW-1] == denom_ff[DW-1]);
   assign t_val = t_neg ? -q_sat : q_sat;

   always_comb begin
      entry_in = entry_ff;
      exit_in  = exit_ff;
      if (denom_ff[DW-1]) begin
         if (t_val > entry_ff) begin
            entry_in = t_val;
         end
      end else if (t_val < exit_ff) begin
         exit_in = t_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         entry_ff  <= '0;
         exit_ff   <= DMAX;
         missed_ff <= 1'b0;
      end else if (cmd.update) begin
         entry_ff  <= entry_in;
         exit_ff   <= exit_in;
         missed_ff <= (entry_in > exit_in);
      end else if (cmd.parallel && !dist_ff[DW-1] && (dist_ff != '0)) begin
         missed_ff <= 1'b1;
      end
   end

   // Result register.
   logic                 rsp_valid_ff;
   logic                 hit_ff;
   logic [T_W-1:0]       t_ff;
   logic signed [63:0]   entry_wide;

   assign entry_wide = 64'(entry_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         hit_ff <= !missed_ff;
         if (missed_ff) begin
            t_ff <= '0;
         end else if (entry_wide > OUT_MAX) begin
            t_ff <= '1;
         end else begin
            t_ff <= entry_wide[T_W-1:0];
         end
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.hit     = hit_ff;
   assign rsp_if.t_entry = t_ff;

   assign status.missed     = missed_ff;
   assign status.last       = last_ff;
   assign status.denom_zero = (denom_ff == '0);
   assign status.rsp_busy   = rsp_valid_ff && !rsp_if.ready;
endmodule
`default_nettype wire

// ===== rtl/ray_convex_polyhedron_clip.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_convex_polyhedron_clip: ray clip against a stream of bounding planes
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// The block takes one plane per beat and works on it alone. A plane that
// arrives while the solid is already missed goes straight to the finish
// step. Otherwise a plane passes the shared 32 by 32 multiplier (seven
// products, each registered), saturation and the parallel test, the
// restoring divider, the update and the finish; a parallel plane skips the
// divider. The result of a solid waits in an output register, so the next
// plane is taken while it is still unread; only a second result that would
// overwrite it stalls the block. Configuration beats are taken at any time,
// but should only be written while no plane is being worked on.
// ----------------------------------------------------------------------------
module ray_convex_polyhedron_clip
   import rcpc_pkg::*;
#(
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rcpc_req_if.sink   req_if,
   rcpc_rsp_if.source rsp_if,
   rcpc_csr_if.sink   csr_if
);
   cmd_type    cmd;
   status_type status;

   // The sequencer owns the plane handshake; the datapath owns the rest.
   rcpc_ctrl #(
      .FRAC_BITS (FRAC_BITS),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .status   (status),
      .cmd      (cmd)
   );

   rcpc_datapath #(
      .FRAC_BITS (FRAC_BITS),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if),
      .cmd   (cmd),
      .status(status)
   );

`ifndef SYNTHESIS
   // A missed solid always reports a zero entry parameter.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.hit |-> rsp_if.t_entry == '0)
      else $error("missed solid with nonzero entry parameter");

   // One plane at a time: an accepted beat closes the input for the next cycle.
   a_one_plane: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("plane accepted while another is in work");

   // A result is only raised by the sequencer's finish step.
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(cmd.emit))
      else $error("result raised without a finish step");
`endif
endmodule
`default_nettype wire

// ===== tb/ray_convex_polyhedron_clip_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_convex_polyhedron_clip_tb: self-checking bench for the ray clip block
// Streams solids built from random and hand-picked planes through the block,
// predicts hit and entry parameter per solid and checks every result beat.
// ----------------------------------------------------------------------------

class clip_scoreboard;
   localparam longint DMAX = 64'sh7FFF_FFFF;
   localparam longint DMIN = -DMAX - 1;

   // Ray registers and per-solid clip state.
   longint ray_reg[7];
   longint t_near;
   longint t_far;
   bit     solid_missed;
   bit     hit_q[$];
   bit [30:0] t_q[$];
   int     n_errors;
   int     n_results;
   int     n_hits;

   function void reset_all();
      foreach (ray_reg[i]) ray_reg[i] = 0;
      ray_reg[rcpc_pkg::CSR_DIR_Z] = 65536;
      ray_reg[rcpc_pkg::CSR_SCALE] = 65536;
      clear_solid();
   endfunction

   function void clear_solid();
      t_near = 0;
      t_far = DMAX;
      solid_missed = 0;
   endfunction

   function void write_reg(int idx, bit [31:0] value);
      if (idx < int'(rcpc_pkg::CSR_SCALE)) ray_reg[idx] = longint'(signed'(value));
      else if (idx == int'(rcpc_pkg::CSR_SCALE))
         ray_reg[rcpc_pkg::CSR_SCALE] = longint'(value[30:0]);
   endfunction

   // Product of two Q16.16 values, shifted down rounding to minus infinity.
   function longint qmul(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   function longint clamp(longint x);
      if (x > DMAX) return DMAX;
      if (x < DMIN) return DMIN;
      return x;
   endfunction

   function longint quotient_mag(longint n, longint d);
      longint q;
      if (n / d > (DMAX >>> 16)) return DMAX;
      q = (n * 65536) / d;
      return (q > DMAX) ? DMAX : q;
   endfunction

   // Notes one accepted plane beat and queues a result on the last plane.
   function void note_plane(bit [31:0] nx, bit [31:0] ny, bit [31:0] nz,
                            bit [31:0] pd, bit last);
      longint sx, sy, sz, sd, denom, dist_val, q, t;
      sx = longint'(signed'(nx));
      sy = longint'(signed'(ny));
      sz = longint'(signed'(nz));
      sd = longint'(signed'(pd));
      if (!solid_missed) begin
         denom = clamp(qmul(sx, ray_reg[rcpc_pkg::CSR_DIR_X])
                       + qmul(sy, ray_reg[rcpc_pkg::CSR_DIR_Y])
                       + qmul(sz, ray_reg[rcpc_pkg::CSR_DIR_Z]));
         dist_val = clamp(qmul(sx, ray_reg[rcpc_pkg::CSR_ORIGIN_X])
                          + qmul(sy, ray_reg[rcpc_pkg::CSR_ORIGIN_Y])
                          + qmul(sz, ray_reg[rcpc_pkg::CSR_ORIGIN_Z])
                          - qmul(sd, ray_reg[rcpc_pkg::CSR_SCALE]));
         if (denom == 0) begin
            if (dist_val > 0) solid_missed = 1;
         end else begin
            q = quotient_mag(dist_val < 0 ? -dist_val : dist_val,
                             denom < 0 ? -denom : denom);
            t = ((dist_val < 0) == (denom < 0)) ? -q : q;
            if (denom < 0) begin
               if (t > t_near) t_near = t;
            end else if (t < t_far) begin
               t_far = t;
            end
            if (t_near > t_far) solid_missed = 1;
         end
      end
      if (last) begin
         hit_q.push_back(!solid_missed);
         t_q.push_back(solid_missed ? 31'd0 : 31'(t_near));
         clear_solid();
      end
   endfunction

   function void check_result(bit hit, bit [30:0] t_entry);
      bit eh;
      bit [30:0] et;
      n_results++;
      if (hit_q.size() == 0) begin
         $display("%0t: unexpected result hit=%0b t_entry=%h", $time, hit, t_entry);
         n_errors++;
         return;
      end
      eh = hit_q.pop_front();
      et = t_q.pop_front();
      n_hits += eh;
      if (hit !== eh) begin
         $display("%0t: hit mismatch, expected %0b, actual %0b", $time, eh, hit);
         n_errors++;
      end
      if (t_entry !== et) begin
         $display("%0t: t_entry mismatch, expected %h, actual %h", $time, et, t_entry);
         n_errors++;
      end
   endfunction
endclass

module ray_convex_polyhedron_clip_tb;
   import rcpc_pkg::*;

   logic clock;
   logic reset;

   rcpc_req_if req_if ();
   rcpc_rsp_if rsp_if ();
   rcpc_csr_if csr_if ();

   ray_convex_polyhedron_clip i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   clip_scoreboard clip_sb;

   // Idling on either side is switched off in the last part of the run.
   bit quiet_tail;
   // Cycles left in the long hold of the receiver.
   int hold_cycles;
   int planes_sent;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop: the slowest correct run is far below this.
   initial begin
      #100ms;
      $display("Simulation FAILED");
      $finish;
   end

   // Result side: ready toggles in random bursts, is held low in the long
   // hold, and every accepted beat goes to the scoreboard.
   initial begin : rsp_side
      int burst;
      rsp_if.ready <= 1'b0;
      burst = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            clip_sb.check_result(rsp_if.hit, rsp_if.t_entry);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_if.ready <= 1'b0;
         end else if (quiet_tail) begin
            rsp_if.ready <= 1'b1;
         end else begin
            if (burst == 0) begin
               burst = $urandom_range(1, 15);
               if ($urandom_range(0, 2) == 0) rsp_if.ready <= 1'b0;
               else rsp_if.ready <= 1'b1;
            end
            burst--;
         end
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      clip_sb.write_reg(idx, value);
      csr_if.valid <= 1'b0;
   endtask

   // Sends one plane beat; a random gap may come first, which puts idle
   // cycles on every phase of the block's work.
   task automatic send_plane(input logic [31:0] nx, input logic [31:0] ny,
                             input logic [31:0] nz, input logic [31:0] pd,
                             input logic last);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.plane_nx <= nx;
      req_if.plane_ny <= ny;
      req_if.plane_nz <= nz;
      req_if.plane_dist <= pd;
      req_if.last_plane <= last;
      do @(posedge clock); while (!req_if.ready);
      clip_sb.note_plane(nx, ny, nz, pd, last);
      planes_sent++;
   endtask

   task automatic wait_drained();
      int guard;
      req_if.valid <= 1'b0;
      guard = 0;
      while (clip_sb.hit_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      // A plane that causes no result may still be in the divider.
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
         3: return 32'h0;
         default: return $urandom();
      endcase
   endfunction

   // Moderate values keep most solids deep in the clip logic rather than
   // saturating; a share of full-range values goes through as noise.
   function automatic logic [31:0] mild();
      return 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
   endfunction

   task automatic program_ray(input logic [31:0] ox, input logic [31:0] oy,
                              input logic [31:0] oz, input logic [31:0] dx,
                              input logic [31:0] dy, input logic [31:0] dz,
                              input logic [31:0] sr);
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_ORIGIN_Z, oz);
      csr_write(CSR_DIR_X, dx);
      csr_write(CSR_DIR_Y, dy);
      csr_write(CSR_DIR_Z, dz);
      csr_write(CSR_SCALE, sr);
   endtask

   // Random solid of one to six planes; the last one carries the mark.
   task automatic random_solid(input bit wild);
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         if (wild)
            send_plane(rand_field(), rand_field(), rand_field(), rand_field(), i == n - 1);
         else
            send_plane(mild(), mild(), mild(), mild(), i == n - 1);
      end
   endtask

   initial begin : stimulus
      clip_sb = new();
      clip_sb.reset_all();
      reset = 1'b1;
      req_if.valid <= 1'b0;
      req_if.plane_nx <= '0;
      req_if.plane_ny <= '0;
      req_if.plane_nz <= '0;
      req_if.plane_dist <= '0;
      req_if.last_plane <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.index <= '0;
      csr_if.data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset ray (origin at zero, heading along +z).
      // A box between z = 1 and z = 3: entry at 1.0.
      send_plane(32'h0, 32'h0, 32'hFFFF_0000, 32'hFFFF_0000, 1'b0);
      send_plane(32'h0, 32'h0, 32'h0001_0000, 32'h0003_0000, 1'b1);
      // Parallel plane with the origin outside, then planes ignored after it.
      send_plane(32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_0000, 1'b0);
      send_plane(32'h0, 32'h0, 32'hFFFF_0000, 32'hFFFF_0000, 1'b1);
      // Parallel plane with the origin inside leaves the solid alone.
      send_plane(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b1);
      // Entry beyond exit.
      send_plane(32'h0, 32'h0, 32'hFFFF_0000, 32'hFFFB_0000, 1'b0);
      send_plane(32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 1'b1);
      // Zero distance: plane through the origin.
      send_plane(32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 1'b1);
      // Extremes of every field, and a tiny denominator for quotient saturation.
      send_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      send_plane(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
      send_plane(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      wait_drained();

      // Extreme ray settings, each followed by a few solids.
      program_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      repeat (4) random_solid(1'b1);
      wait_drained();
      program_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      repeat (4) random_solid(1'b1);
      wait_drained();

      // Receiver holds off for a long stretch while planes keep coming, so
      // the output register fills and the input stalls.
      program_ray(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
      hold_cycles = 1500;
      repeat (8) send_plane(mild(), mild(), mild(), mild(), 1'b1);
      wait_drained();

      // Random phases: a fresh ray per phase, mostly well-formed solids.
      while (planes_sent < 1500) begin
         if (planes_sent > 1250) quiet_tail = 1'b1;
         if ($urandom_range(0, 3) == 0)
            program_ray(rand_field(), rand_field(), rand_field(), rand_field(),
                        rand_field(), rand_field(), rand_field());
         else
            program_ray(mild(), mild(), mild(), mild(), mild(), mild(),
                        32'($urandom_range(1 << 14, 1 << 18)));
         repeat ($urandom_range(5, 20))
            random_solid($urandom_range(0, 4) == 0);
         wait_drained();
      end

      $display("Covered %0d planes and %0d solids (%0d hits) over many ray settings,",
               planes_sent, clip_sb.n_results, clip_sb.n_hits);
      $display("including misses, parallel planes, saturation and a long output stall.");
      if (clip_sb.n_errors == 0 && clip_sb.hit_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rcpc_pkg.sv
rtl/rcpc_req_if.sv
rtl/rcpc_rsp_if.sv
rtl/rcpc_csr_if.sv
rtl/rcpc_ctrl.sv
rtl/rcpc_datapath.sv
rtl/ray_convex_polyhedron_clip.sv
tb/ray_convex_polyhedron_clip_tb.sv
